### hdl/rce_pkg.sv
// Shared types, codes and character functions of the radix character encoder.
package rce_pkg;

    localparam logic [7:0] DEFAULT_LINE_WIDTH = 8'd75;

    localparam logic [1:0] REG_RADIX  = 2'd0;
    localparam logic [1:0] REG_MODE   = 2'd1;
    localparam logic [1:0] REG_LIMIT  = 2'd2;
    localparam logic [1:0] REG_INDENT = 2'd3;

    localparam logic [1:0] RADIX_HEX = 2'd1;
    localparam logic [1:0] RADIX_B64 = 2'd2;

    localparam logic [1:0] MODE_B64 = 2'd1;
    localparam logic [1:0] MODE_ADV = 2'd2;

    localparam logic [2:0] SEL_NL   = 3'd0;
    localparam logic [2:0] SEL_SP   = 3'd1;
    localparam logic [2:0] SEL_DIG  = 3'd2;
    localparam logic [2:0] SEL_FDIG = 3'd3;
    localparam logic [2:0] SEL_PAD  = 3'd4;

    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SP     = 8'h20;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_BAR    = 8'h7C;

    typedef struct packed {
        logic       emit;
        logic [2:0] sel;
        logic       last;
        logic       load_byte;
        logic       dig_step;
        logic       phase_inc;
        logic       clear;
        logic       load_sp;
        logic       dec_sp;
    } t_cmd;

    typedef struct packed {
        logic can_emit;
        logic brk_cond;
        logic dig_need_brk;
        logic pend_ge_2w;
        logic flush_partial;
        logic is_b64;
        logic phase_nz;
        logic phase_is3;
        logic nsp_nz;
        logic sp_is1;
    } t_status;

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        logic [7:0] r;
        if (v < 4'd10) begin
            r = 8'h30 + {4'd0, v};
        end else begin
            r = 8'h41 + {4'd0, v} - 8'd10;
        end
        return r;
    endfunction

    function automatic logic [7:0] b64_char(input logic [5:0] v);
        logic [7:0] r;
        if (v < 6'd26) begin
            r = 8'h41 + {2'd0, v};
        end else if (v < 6'd52) begin
            r = 8'h61 + {2'd0, v} - 8'd26;
        end else if (v < 6'd62) begin
            r = 8'h30 + {2'd0, v} - 8'd52;
        end else if (v == 6'd62) begin
            r = 8'h2B;
        end else begin
            r = 8'h2F;
        end
        return r;
    endfunction

endpackage

### hdl/rce_ctrl.sv
// Controller state machine that sequences breaks, indent, digits and padding.
module rce_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_kind,
    input  rce_pkg::t_status  i_st,
    output rce_pkg::t_cmd     o_cmd,
    output logic              o_busy
);
    import rce_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_UNIT = 2'd1;
    localparam logic [1:0] S_SP   = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    localparam logic [1:0] U_DIG  = 2'd0;
    localparam logic [1:0] U_FDIG = 2'd1;
    localparam logic [1:0] U_PAD  = 2'd2;

    logic [1:0] r_state, n_state;
    logic [1:0] r_unit, n_unit;
    t_cmd       cmd;
    logic       brk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_unit  <= U_DIG;
        end else begin
            r_state <= n_state;
            r_unit  <= n_unit;
        end
    end

    always_comb begin
        cmd     = '0;
        n_state = r_state;
        n_unit  = r_unit;
        brk     = i_st.brk_cond && (r_unit == U_PAD || i_st.dig_need_brk);
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (!i_kind) begin
                        cmd.load_byte = 1'b1;
                        n_unit        = U_DIG;
                        n_state       = S_UNIT;
                    end else if (i_st.flush_partial) begin
                        n_unit  = U_FDIG;
                        n_state = S_EMIT;
                    end else if (i_st.is_b64 && i_st.phase_nz) begin
                        n_unit  = U_PAD;
                        n_state = S_UNIT;
                    end else begin
                        cmd.clear = 1'b1;
                    end
                end
            end
            S_SP: begin
                if (i_st.can_emit) begin
                    cmd.emit   = 1'b1;
                    cmd.sel    = SEL_SP;
                    cmd.dec_sp = 1'b1;
                    if (i_st.sp_is1) begin
                        n_state = S_EMIT;
                    end
                end
            end
            default: begin
                if (i_st.can_emit) begin
                    cmd.emit = 1'b1;
                    if (r_state == S_UNIT && brk) begin
                        cmd.sel     = SEL_NL;
                        cmd.load_sp = 1'b1;
                        n_state     = i_st.nsp_nz ? S_SP : S_EMIT;
                    end else begin
                        unique case (r_unit)
                            U_DIG: begin
                                cmd.sel      = SEL_DIG;
                                cmd.dig_step = 1'b1;
                                cmd.last     = !i_st.pend_ge_2w;
                                n_state      = i_st.pend_ge_2w ? S_UNIT : S_IDLE;
                            end
                            U_FDIG: begin
                                cmd.sel = SEL_FDIG;
                                if (i_st.is_b64 && !i_st.phase_is3) begin
                                    cmd.phase_inc = 1'b1;
                                    n_unit        = U_PAD;
                                    n_state       = S_UNIT;
                                end else begin
                                    cmd.last  = 1'b1;
                                    cmd.clear = 1'b1;
                                    n_state   = S_IDLE;
                                end
                            end
                            default: begin
                                cmd.sel = SEL_PAD;
                                if (i_st.phase_is3) begin
                                    cmd.last  = 1'b1;
                                    cmd.clear = 1'b1;
                                    n_state   = S_IDLE;
                                end else begin
                                    cmd.phase_inc = 1'b1;
                                    n_state       = S_UNIT;
                                end
                            end
                        endcase
                    end
                end
            end
        endcase
    end

    assign o_cmd  = cmd;
    assign o_busy = (r_state != S_IDLE);

endmodule

### hdl/rce_datapath.sv
// Datapath with configuration, bit accumulator, counters and output register.
module rce_datapath #(
    parameter logic [7:0] LINE_LIMIT_RESET = rce_pkg::DEFAULT_LINE_WIDTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [7:0]        i_cfg_data,
    input  logic [7:0]        i_data_byte,
    input  rce_pkg::t_cmd     i_cmd,
    output rce_pkg::t_status  o_st,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [7:0]        o_out_char,
    output logic              o_last
);
    import rce_pkg::*;

    logic [1:0]  r_radix;
    logic [1:0]  r_mode;
    logic [7:0]  r_limit;
    logic [3:0]  r_indent;
    logic [11:0] r_acc, n_acc;
    logic [3:0]  r_pend, n_pend;
    logic [7:0]  r_col;
    logic [1:0]  r_phase, n_phase;
    logic [7:0]  r_byte;
    logic [3:0]  r_sp;
    logic        r_out_valid;
    logic [7:0]  r_out_char;
    logic        r_out_last;

    logic [3:0]  w;
    logic [3:0]  pend_minus_w;
    logic [11:0] dig_val;
    logic [11:0] fdig_val;
    logic [7:0]  dig_char;
    logic [7:0]  fdig_char;
    logic [7:0]  sel_char;
    logic [8:0]  ceil_sum;
    logic [6:0]  ceil_q;
    logic [3:0]  nsp;
    logic        special;

    always_comb begin
        unique case (r_radix)
            RADIX_HEX: w = 4'd4;
            RADIX_B64: w = 4'd6;
            default:   w = 4'd8;
        endcase
    end

    assign pend_minus_w = r_pend - w;
    assign dig_val      = r_acc >> pend_minus_w;
    assign fdig_val     = r_acc << (w - r_pend);

    always_comb begin
        unique case (r_radix)
            RADIX_HEX: begin
                dig_char  = hex_char(dig_val[3:0]);
                fdig_char = hex_char(fdig_val[3:0]);
            end
            RADIX_B64: begin
                dig_char  = b64_char(dig_val[5:0]);
                fdig_char = b64_char(fdig_val[5:0]);
            end
            default: begin
                dig_char  = dig_val[7:0];
                fdig_char = fdig_val[7:0];
            end
        endcase
    end

    always_comb begin
        unique case (i_cmd.sel)
            SEL_NL:   sel_char = CH_NL;
            SEL_SP:   sel_char = CH_SP;
            SEL_DIG:  sel_char = dig_char;
            SEL_FDIG: sel_char = fdig_char;
            default:  sel_char = CH_EQ;
        endcase
    end

    assign ceil_sum = {1'b0, r_limit} + 9'd3;
    assign ceil_q   = ceil_sum[8:2];
    assign nsp      = (r_mode != MODE_ADV) ? 4'd0 :
                      ({3'd0, r_indent} < ceil_q) ? r_indent : ceil_q[3:0];
    assign special  = (r_byte == CH_LBRACE) || (r_byte == CH_RBRACE) ||
                      (r_byte == CH_HASH) || (r_byte == CH_BAR);

    assign o_st.can_emit      = !r_out_valid || !i_stall;
    assign o_st.brk_cond      = (r_limit != 8'd0) && (r_col >= r_limit) &&
                                (r_mode == MODE_B64 || r_mode == MODE_ADV);
    assign o_st.dig_need_brk  = (w != 4'd8) || special;
    assign o_st.pend_ge_2w    = {1'b0, r_pend} >= {w, 1'b0};
    assign o_st.flush_partial = (r_pend != 4'd0) && (r_pend < w);
    assign o_st.is_b64        = (r_radix == RADIX_B64);
    assign o_st.phase_nz      = (r_phase != 2'd0);
    assign o_st.phase_is3     = (r_phase == 2'd3);
    assign o_st.nsp_nz        = (nsp != 4'd0);
    assign o_st.sp_is1        = (r_sp == 4'd1);

    always_comb begin
        n_acc   = r_acc;
        n_pend  = r_pend;
        n_phase = r_phase;
        if (i_cmd.load_byte) begin
            n_acc  = {r_acc[3:0], i_data_byte};
            n_pend = r_pend + 4'd8;
        end
        if (i_cmd.dig_step) begin
            n_pend  = pend_minus_w;
            n_acc   = r_acc & ((12'd1 << pend_minus_w) - 12'd1);
            n_phase = r_phase + 2'd1;
        end
        if (i_cmd.phase_inc) begin
            n_phase = r_phase + 2'd1;
        end
        if (i_cmd.clear || (i_cfg_we && i_cfg_idx == REG_RADIX)) begin
            n_acc   = '0;
            n_pend  = '0;
            n_phase = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix     <= '0;
            r_mode      <= '0;
            r_limit     <= LINE_LIMIT_RESET;
            r_indent    <= '0;
            r_acc       <= '0;
            r_pend      <= '0;
            r_col       <= '0;
            r_phase     <= '0;
            r_sp        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_acc   <= n_acc;
            r_pend  <= n_pend;
            r_phase <= n_phase;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_RADIX:  r_radix  <= i_cfg_data[1:0];
                    REG_MODE:   r_mode   <= i_cfg_data[1:0];
                    REG_LIMIT:  r_limit  <= i_cfg_data;
                    REG_INDENT: r_indent <= i_cfg_data[3:0];
                endcase
            end
            if (i_cmd.load_sp) begin
                r_sp <= nsp;
            end else if (i_cmd.dec_sp) begin
                r_sp <= r_sp - 4'd1;
            end
            if (i_cmd.emit) begin
                if (i_cmd.sel == SEL_NL) begin
                    r_col <= '0;
                end else if (r_col != 8'hFF) begin
                    r_col <= r_col + 8'd1;
                end
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_byte) begin
            r_byte <= i_data_byte;
        end
        if (i_cmd.emit) begin
            r_out_char <= sel_char;
            r_out_last <= i_cmd.last;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_out_char = r_out_char;
    assign o_last     = r_out_last;

endmodule

### hdl/radix_char_encoder_line_wrap.sv
// Top level of the radix character encoder with automatic line wrapping.
//
//   Channel   Direction  Handshake          Payload
//   input     in         i_valid / o_stall  i_kind, i_data_byte
//   result    out        o_valid / i_stall  o_out_char, o_last
//   config    in         i_cfg_we           i_cfg_idx, i_cfg_data
//
// A request is accepted first and then sends its characters.
// A line break adds a newline and, in the advanced mode, the indent spaces.
// The single output register emits one character per cycle unless the result side stalls.
// Reset is synchronous and active low; no clearing pass is needed.
// A stall on the result side holds the sequencer; the next request waits.
module radix_char_encoder_line_wrap #(
    parameter logic [7:0] LINE_LIMIT_RESET = rce_pkg::DEFAULT_LINE_WIDTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_kind,
    input  logic [7:0] i_data_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_char,
    output logic       o_last
);
    import rce_pkg::*;

    t_cmd    cmd;
    t_status st;
    logic    busy;

    rce_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_kind  (i_kind),
        .i_st    (st),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    rce_datapath #(
        .LINE_LIMIT_RESET (LINE_LIMIT_RESET)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_data_byte (i_data_byte),
        .i_cmd       (cmd),
        .o_st        (st),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_char  (o_out_char),
        .o_last      (o_last)
    );

    assign o_stall = busy;

    a_byte_starts_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && !i_kind) |=> o_stall)
        else $error("A data byte request did not start character output.");

    a_partial_keeps_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> o_stall)
        else $error("A non-final character is shown while the sequencer is idle.");

endmodule

### tb/rce_char_checker.sv
// Checker that predicts the encoder's characters and compares them with its output.
module rce_char_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    input  logic       i_req_valid,
    input  logic       i_req_stall,
    input  logic       i_req_kind,
    input  logic [7:0] i_req_byte,
    input  logic       i_char_valid,
    input  logic       i_char_stall,
    input  logic [7:0] i_char,
    input  logic       i_char_last,
    output int         o_chars_due,
    output int         o_mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    import rce_pkg::*;

    localparam logic [127:0] HEX_DIGITS = "0123456789ABCDEF";
    localparam logic [511:0] B64_DIGITS =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    localparam int BURST_MAX = 36;

    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } t_char_due;

    t_char_due   chars_due[$];
    logic [7:0]  burst[BURST_MAX];
    int          burst_len;
    int          mismatch_count;

    logic [1:0]  radix_q;
    logic [1:0]  mode_q;
    logic [7:0]  limit_q;
    logic [3:0]  indent_q;
    logic [11:0] acc_q;
    logic [3:0]  pend_q;
    logic [7:0]  col_q;
    logic [1:0]  phase_q;

    function automatic logic [7:0] hex_digit(input logic [3:0] n);
        return HEX_DIGITS[8 * (15 - int'(n)) +: 8];
    endfunction

    function automatic logic [7:0] b64_digit(input logic [5:0] s);
        return B64_DIGITS[8 * (63 - int'(s)) +: 8];
    endfunction

    function automatic logic [3:0] digit_bits();
        if (radix_q == RADIX_HEX) begin
            return 4'd4;
        end else if (radix_q == RADIX_B64) begin
            return 4'd6;
        end
        return 4'd8;
    endfunction

    function automatic void put_char(input logic [7:0] code);
        if (burst_len < BURST_MAX) begin
            burst[burst_len] = code;
            burst_len++;
        end
        if (col_q != 8'hFF) begin
            col_q = col_q + 8'd1;
        end
    endfunction

    function automatic void line_break();
        int i;
        if (limit_q == 8'd0 || col_q < limit_q) begin
            return;
        end
        if (mode_q == MODE_B64 || mode_q == MODE_ADV) begin
            put_char(CH_NL);
            col_q = 8'd0;
        end
        if (mode_q == MODE_ADV) begin
            for (i = 0; i < int'(indent_q) && 4 * i < int'(limit_q); i++) begin
                put_char(CH_SP);
            end
        end
    endfunction

    function automatic void clear_digits();
        acc_q   = 12'd0;
        pend_q  = 4'd0;
        phase_q = 2'd0;
    endfunction

    function automatic void encode_byte(input logic [7:0] b);
        logic [3:0]  w;
        logic [11:0] t;
        w = digit_bits();
        acc_q = {acc_q[3:0], b};
        pend_q = pend_q + 4'd8;
        while (pend_q >= w && pend_q <= 4'd12) begin
            if (w != 4'd8 || b == CH_LBRACE || b == CH_RBRACE || b == CH_HASH || b == CH_BAR) begin
                line_break();
            end
            t = acc_q >> (pend_q - w);
            if (w == 4'd4) begin
                put_char(hex_digit(t[3:0]));
            end else if (w == 4'd6) begin
                put_char(b64_digit(t[5:0]));
            end else begin
                put_char(acc_q[7:0]);
            end
            pend_q = pend_q - w;
            phase_q = phase_q + 2'd1;
        end
        if (pend_q < 4'd12) begin
            acc_q = acc_q & ((12'd1 << pend_q) - 12'd1);
        end
    endfunction

    function automatic void flush_bits();
        logic [3:0]  w;
        logic [11:0] t;
        w = digit_bits();
        if (pend_q > 4'd0 && pend_q < w) begin
            t = acc_q << (w - pend_q);
            if (w == 4'd4) begin
                put_char(hex_digit(t[3:0]));
            end else if (w == 4'd6) begin
                put_char(b64_digit(t[5:0]));
            end else begin
                put_char(acc_q[7:0]);
            end
            phase_q = phase_q + 2'd1;
        end
        if (w == 4'd6) begin
            while (phase_q != 2'd0) begin
                line_break();
                put_char(CH_EQ);
                phase_q = phase_q + 2'd1;
            end
        end
        clear_digits();
    endfunction

    function automatic void encode_request(input logic is_flush, input logic [7:0] b);
        int k;
        burst_len = 0;
        if (is_flush) begin
            flush_bits();
        end else begin
            encode_byte(b);
        end
        for (k = 0; k < burst_len; k++) begin
            chars_due.push_back({burst[k], k == burst_len - 1});
        end
    endfunction

    function automatic void write_register(input logic [1:0] idx, input logic [7:0] data);
        case (idx)
            REG_RADIX: begin
                radix_q = data[1:0];
                clear_digits();
            end
            REG_MODE: begin
                mode_q = data[1:0];
            end
            REG_LIMIT: begin
                limit_q = data;
            end
            default: begin
                indent_q = data[3:0];
            end
        endcase
    endfunction

    function automatic void compare_char(input logic [7:0] code, input logic last);
        t_char_due want;
        if (chars_due.size() == 0) begin
            if (mismatch_count < 10) begin
                $display("%0t: unexpected character %h last %b", $realtime, code, last);
            end
            mismatch_count++;
            return;
        end
        want = chars_due.pop_front();
        if (code !== want.code || last !== want.last) begin
            if (mismatch_count < 10) begin
                $display("%0t: character %h last %b, expected %h last %b",
                         $realtime, code, last, want.code, want.last);
            end
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            radix_q  = 2'd0;
            mode_q   = 2'd0;
            limit_q  = DEFAULT_LINE_WIDTH;
            indent_q = 4'd0;
            col_q    = 8'd0;
            clear_digits();
            chars_due.delete();
        end else begin
            if (i_cfg_we) begin
                write_register(i_cfg_idx, i_cfg_data);
            end
            if (i_req_valid && !i_req_stall) begin
                encode_request(i_req_kind, i_req_byte);
            end
            if (i_char_valid && !i_char_stall) begin
                compare_char(i_char, i_char_last);
            end
        end
        o_chars_due  <= chars_due.size();
        o_mismatches <= mismatch_count;
    end

endmodule

### tb/tb_radix_char_encoder_line_wrap.sv
// Testbench top: drives requests and register writes into the encoder and gives the verdict.
module tb_radix_char_encoder_line_wrap;
    timeunit 1ns;
    timeprecision 1ps;

    import rce_pkg::*;

    localparam logic       KIND_DATA   = 1'b0;
    localparam logic       KIND_FLUSH  = 1'b1;
    localparam logic [1:0] RADIX_RAW   = 2'd0;
    localparam logic [1:0] RADIX_SPARE = 2'd3;
    localparam logic [1:0] MODE_CANON  = 2'd0;
    localparam logic [1:0] MODE_SPARE  = 2'd3;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_cfg_we    = 1'b0;
    logic [1:0] i_cfg_idx   = 2'd0;
    logic [7:0] i_cfg_data  = 8'd0;
    logic       i_valid     = 1'b0;
    logic       i_kind      = 1'b0;
    logic [7:0] i_data_byte = 8'd0;
    logic       i_stall     = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [7:0] o_out_char;
    logic       o_last;

    int chars_due;
    int mismatches;
    int send_idle_pct = 37;
    int recv_idle_pct = 74;

    radix_char_encoder_line_wrap u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_kind      (i_kind),
        .i_data_byte (i_data_byte),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_char  (o_out_char),
        .o_last      (o_last)
    );

    rce_char_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_req_valid  (i_valid),
        .i_req_stall  (o_stall),
        .i_req_kind   (i_kind),
        .i_req_byte   (i_data_byte),
        .i_char_valid (o_valid),
        .i_char_stall (i_stall),
        .i_char       (o_out_char),
        .i_char_last  (o_last),
        .o_chars_due  (chars_due),
        .o_mismatches (mismatches)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    task automatic send_request(input logic kind, input logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_kind      <= kind;
        i_data_byte <= b;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (chars_due != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic apply_settings(input logic [1:0] radix, input logic [1:0] mode,
                                  input logic [7:0] limit, input logic [3:0] indent);
        logic [7:0] junk;
        junk = 8'($urandom);
        wait_idle();
        write_reg(REG_RADIX, {junk[7:2], radix});
        write_reg(REG_MODE, {junk[5:0], mode});
        write_reg(REG_LIMIT, limit);
        write_reg(REG_INDENT, {junk[3:0], indent});
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_random(input int count);
        int         k;
        logic       kind;
        logic [7:0] b;
        for (k = 0; k < count; k++) begin
            kind = ($urandom_range(0, 99) < 12) ? KIND_FLUSH : KIND_DATA;
            b = 8'($urandom);
            if ($urandom_range(0, 3) == 0) begin
                case ($urandom_range(0, 3))
                    0: b = CH_LBRACE;
                    1: b = CH_RBRACE;
                    2: b = CH_HASH;
                    default: b = CH_BAR;
                endcase
            end
            send_request(kind, b);
        end
    endtask

    initial begin
        int p;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        apply_settings(RADIX_HEX, MODE_ADV, 8'd4, 4'd15);
        send_request(KIND_DATA, 8'h00);
        send_request(KIND_DATA, 8'hFF);
        send_request(KIND_DATA, 8'hA5);
        send_request(KIND_DATA, 8'h5A);
        send_request(KIND_FLUSH, 8'hFF);

        apply_settings(RADIX_B64, MODE_B64, 8'd1, 4'd0);
        send_request(KIND_DATA, 8'h00);
        send_request(KIND_DATA, 8'hFF);
        send_request(KIND_FLUSH, 8'h00);
        send_request(KIND_DATA, 8'h80);
        send_request(KIND_FLUSH, 8'h00);
        send_request(KIND_DATA, 8'h4D);
        send_request(KIND_DATA, 8'h61);
        send_request(KIND_DATA, 8'h6E);
        send_request(KIND_FLUSH, 8'h00);

        apply_settings(RADIX_RAW, MODE_ADV, 8'd2, 4'd3);
        send_request(KIND_DATA, CH_LBRACE);
        send_request(KIND_DATA, CH_RBRACE);
        send_request(KIND_DATA, CH_HASH);
        send_request(KIND_DATA, CH_BAR);
        send_request(KIND_DATA, 8'h41);
        send_request(KIND_DATA, 8'h00);
        send_request(KIND_DATA, 8'hFF);
        send_request(KIND_FLUSH, 8'h00);

        apply_settings(RADIX_SPARE, MODE_SPARE, 8'd0, 4'd15);
        send_request(KIND_DATA, CH_LBRACE);
        send_request(KIND_DATA, 8'h7F);
        send_request(KIND_FLUSH, 8'h00);

        for (p = 0; p < 9; p++) begin
            if (p == 3) begin
                send_idle_pct = 74;
                recv_idle_pct = 37;
            end else if (p == 6) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (p)
                0: apply_settings(RADIX_HEX, MODE_CANON, 8'd0, 4'd0);
                1: apply_settings(RADIX_B64, MODE_SPARE, 8'd255, 4'd15);
                2: apply_settings(RADIX_B64, MODE_ADV, 8'($urandom_range(1, 12)),
                                  4'($urandom));
                3: apply_settings(RADIX_RAW, MODE_ADV, 8'($urandom_range(1, 8)), 4'd15);
                4: apply_settings(RADIX_HEX, MODE_B64, 8'($urandom_range(1, 20)),
                                  4'($urandom));
                5: apply_settings(RADIX_B64, MODE_B64, 8'd255, 4'd0);
                6: apply_settings(RADIX_SPARE, MODE_ADV, 8'd1, 4'd15);
                7: apply_settings(RADIX_B64, MODE_ADV, 8'd3, 4'd1);
                default: apply_settings(2'($urandom), 2'($urandom), 8'($urandom),
                                        4'($urandom));
            endcase
            send_random(16);
        end

        wait_idle();
        @(negedge i_clk);
        if (mismatches == 0) begin
            $display("tb_radix_char_encoder_line_wrap OK");
        end else begin
            $display("tb_radix_char_encoder_line_wrap NOT OK");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("tb_radix_char_encoder_line_wrap NOT OK");
        $finish;
    end

endmodule

### radix_char_encoder_line_wrap.f
hdl/rce_pkg.sv
hdl/rce_ctrl.sv
hdl/rce_datapath.sv
hdl/radix_char_encoder_line_wrap.sv
tb/rce_char_checker.sv
tb/tb_radix_char_encoder_line_wrap.sv
